### hw/rtl/assert_macros.svh
// assertion macros for the phe_checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PHE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phe check failed");

// next-cycle implication, disabled while reset is low
`define PHE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phe check failed");

`endif

### hw/rtl/phe_pkg.sv
// types and constants of the horner evaluator
// no dependencies
package phe_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int OPC_W  = 2;
    localparam int IDX_W  = 4;
    localparam int DEG_W  = 4;
    localparam int CNT_W  = DEG_W + 1;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_EVAL  = 2'd1,
        OP_DERIV = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // one coefficient read travelling down the datapath
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic [DEG_W-1:0] scale;
    } term_ctl_t;

    typedef struct packed {
        logic done;
        logic overflow;
    } acc_stat_t;

endpackage

### hw/rtl/phe_in_if.sv
// request channel of the horner evaluator
// depends on phe_pkg
interface phe_in_if;
    import phe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OPC_W-1:0]         opcode;
    logic [IDX_W-1:0]         coeff_index;
    logic signed [DATA_W-1:0] coeff_value;
    logic signed [DATA_W-1:0] point;

    modport source (output valid, opcode, coeff_index, coeff_value, point, input ready);
    modport sink (input valid, opcode, coeff_index, coeff_value, point, output ready);
endinterface

### hw/rtl/phe_out_if.sv
// result channel of the horner evaluator
// depends on phe_pkg
interface phe_out_if;
    import phe_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     overflow;

    modport source (output valid, value, overflow, input ready);
    modport sink (input valid, value, overflow, output ready);
endinterface

### hw/rtl/phe_coeff_ram.sv
// coefficient store: one write port, one registered read port
// depends on phe_pkg
module phe_coeff_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [phe_pkg::DATA_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [phe_pkg::DATA_W-1:0] rd_data
);
    import phe_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/phe_mac.sv
// scale stage and horner multiply-add stage with saturation
// depends on phe_pkg
module phe_mac (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  phe_pkg::term_ctl_t               term,
    input  logic signed [phe_pkg::DATA_W-1:0] coeff,
    input  logic signed [phe_pkg::DATA_W-1:0] x,
    output logic signed [phe_pkg::DATA_W-1:0] result,
    output phe_pkg::acc_stat_t               stat
);
    import phe_pkg::*;

    localparam int SCL_W  = DATA_W + DEG_W + 1;
    localparam int PROD_W = 2 * DATA_W;
    localparam int Q_W    = PROD_W - FRAC_W;
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    logic signed [SCL_W-1:0]  scaled;
    logic                     scale_ovf;
    logic [DATA_W-1:0]        scale_sat;
    logic signed [PROD_W-1:0] prod;
    logic [Q_W-1:0]           prod_q;
    logic                     mul_ovf;
    logic [DATA_W-1:0]        mul_sat;
    logic [DATA_W:0]          sum;
    logic                     add_ovf;
    logic [DATA_W-1:0]        sum_sat;
    logic                     step_ovf;

    term_ctl_t                t_ctl_reg;
    logic [DATA_W-1:0]        t_reg;
    logic signed [DATA_W-1:0] b_reg;
    logic                     done_reg;
    logic                     ovf_reg;

    // derivative weight (degree - i), one for a plain evaluation
    assign scaled    = SCL_W'(coeff) * SCL_W'($signed({1'b0, term.scale}));
    assign scale_ovf = scaled[SCL_W-1:DATA_W-1] != {(SCL_W-DATA_W+1){scaled[SCL_W-1]}};
    assign scale_sat = scale_ovf ? (scaled[SCL_W-1] ? SAT_MIN : SAT_MAX) : scaled[DATA_W-1:0];

    // floor shift of the product is just dropping the low fraction bits
    assign prod    = PROD_W'(b_reg) * PROD_W'(x);
    assign prod_q  = prod[PROD_W-1:FRAC_W];
    assign mul_ovf = prod_q[Q_W-1:DATA_W-1] != {(Q_W-DATA_W+1){prod_q[Q_W-1]}};
    assign mul_sat = mul_ovf ? (prod_q[Q_W-1] ? SAT_MIN : SAT_MAX) : prod_q[DATA_W-1:0];

    assign sum      = {mul_sat[DATA_W-1], mul_sat} + {t_reg[DATA_W-1], t_reg};
    assign add_ovf  = sum[DATA_W] != sum[DATA_W-1];
    assign sum_sat  = add_ovf ? (sum[DATA_W] ? SAT_MIN : SAT_MAX) : sum[DATA_W-1:0];
    assign step_ovf = t_ctl_reg.valid && !t_ctl_reg.first && (mul_ovf || add_ovf);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_ctl_reg <= '0;
            done_reg  <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            t_ctl_reg <= term;
            done_reg  <= t_ctl_reg.valid && t_ctl_reg.last;
            if (start)
            begin
                ovf_reg <= 1'b0;
            end
            else
            begin
                ovf_reg <= ovf_reg || (term.valid && scale_ovf) || step_ovf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (term.valid)
        begin
            t_reg <= scale_sat;
        end
        if (t_ctl_reg.valid)
        begin
            b_reg <= t_ctl_reg.first ? $signed(t_reg) : $signed(sum_sat);
        end
    end

    assign result        = b_reg;
    assign stat.done     = done_reg;
    assign stat.overflow = ovf_reg;

endmodule

### hw/rtl/polynomial_horner_evaluator_unit.sv
// top level of the horner polynomial evaluator, signed Q16.16
// depends on phe_pkg, phe_in_if, phe_out_if, phe_coeff_ram, phe_mac
//
// req carries one item per beat: a load (opcode 0) writes coeff_value into slot
// coeff_index and gives no result; evaluate (1) and derivative (2) give one rsp
// beat with the value at point and an overflow flag. opcode 3 is dropped.
// cfg_wr_en/cfg_wr_data set the degree D; write it only while the block is idle.
// a load is written at its accept and leaves req.ready high. an evaluation
// reads n coefficients from the store, one per cycle (n = D+1, or D for a
// derivative), through a scale stage and one multiply-add stage; at the end
// the result enters the rsp register and req.ready returns in the same cycle,
// so no new item is taken before. a derivative of a constant answers 0 without
// reading the store. the store has a single coefficient read port.
// reset clears the control and sets D to 0; coefficients are undefined until
// loaded. a stalled rsp beat holds in the output register while the next item
// is accepted and computed; its result then waits until rsp is taken.
module polynomial_horner_evaluator_unit #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [phe_pkg::DEG_W-1:0] cfg_wr_data,
    phe_in_if.sink                    req,
    phe_out_if.source                 rsp
);
    import phe_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int PAD_W = (AW > CNT_W) ? AW : CNT_W;

    state_t                   state_reg, state_next;
    logic [DEG_W-1:0]         deg_cfg_reg;
    logic [DEG_W-1:0]         deg_eff;
    logic [DEG_W-1:0]         deg_reg;
    logic                     deriv_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         iss_cnt_reg;
    logic signed [DATA_W-1:0] x_reg;
    term_ctl_t                rd_ctl_reg;
    term_ctl_t                rd_ctl_next;
    logic [DATA_W-1:0]        res_value_reg;
    logic                     res_ovf_reg;
    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_value_reg;
    logic                     out_ovf_reg;

    logic                     req_fire;
    logic                     is_eval;
    logic                     zero_deriv;
    logic                     start;
    logic                     issue;
    logic                     out_free;
    logic                     out_load;
    logic                     wr_en;
    logic [PAD_W-1:0]         wr_addr_wide;
    logic [PAD_W-1:0]         rd_addr_wide;
    logic [DATA_W-1:0]        rd_data;
    logic signed [DATA_W-1:0] mac_result;
    acc_stat_t                mac_stat;

    assign deg_eff = (PAD_W'(deg_cfg_reg) > PAD_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE)
                                                                 : deg_cfg_reg;

    assign req_fire     = req.valid && req.ready;
    assign is_eval      = (req.opcode == OP_EVAL) || (req.opcode == OP_DERIV);
    assign zero_deriv   = (req.opcode == OP_DERIV) && (deg_eff == '0);
    assign start        = req_fire && is_eval;
    assign wr_addr_wide = PAD_W'(req.coeff_index);
    assign wr_en        = req_fire && (req.opcode == OP_LOAD)
                          && (wr_addr_wide <= PAD_W'(MAX_DEGREE));
    assign rd_addr_wide = PAD_W'(iss_cnt_reg);
    assign out_free     = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next  = state_reg;
        req.ready   = 1'b0;
        issue       = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && is_eval)
                begin
                    state_next = zero_deriv ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN:
            begin
                issue = iss_cnt_reg < n_reg;
                if (mac_stat.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_ctl_next.valid = issue;
        rd_ctl_next.first = iss_cnt_reg == '0;
        rd_ctl_next.last  = iss_cnt_reg == (n_reg - CNT_W'(1));
        rd_ctl_next.scale = deriv_reg ? (deg_reg - iss_cnt_reg[DEG_W-1:0]) : DEG_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            deg_cfg_reg   <= '0;
            iss_cnt_reg   <= '0;
            rd_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ctl_reg <= rd_ctl_next;
            if (cfg_wr_en)
            begin
                deg_cfg_reg <= cfg_wr_data;
            end
            if (start)
            begin
                iss_cnt_reg <= '0;
            end
            else if (issue)
            begin
                iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg     <= req.point;
            deriv_reg <= req.opcode == OP_DERIV;
            deg_reg   <= deg_eff;
            n_reg     <= (req.opcode == OP_DERIV) ? CNT_W'(deg_eff)
                                                  : CNT_W'(deg_eff) + CNT_W'(1);
        end
        if (start && zero_deriv)
        begin
            res_value_reg <= '0;
            res_ovf_reg   <= 1'b0;
        end
        else if (state_reg == ST_RUN && mac_stat.done)
        begin
            res_value_reg <= mac_result;
            res_ovf_reg   <= mac_stat.overflow;
        end
        if (out_load)
        begin
            out_value_reg <= res_value_reg;
            out_ovf_reg   <= res_ovf_reg;
        end
    end

    phe_coeff_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_coeff_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_wide[AW-1:0]),
        .wr_data (req.coeff_value),
        .rd_en   (issue),
        .rd_addr (rd_addr_wide[AW-1:0]),
        .rd_data (rd_data)
    );

    phe_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .term   (rd_ctl_reg),
        .coeff  ($signed(rd_data)),
        .x      (x_reg),
        .result (mac_result),
        .stat   (mac_stat)
    );

    assign rsp.valid    = out_valid_reg;
    assign rsp.value    = out_value_reg;
    assign rsp.overflow = out_ovf_reg;

endmodule

### hw/rtl/phe_checker.sv
// port-level checks of the horner evaluator, bound to the top level
// depends on phe_pkg, assert_macros.svh, polynomial_horner_evaluator_unit
`include "assert_macros.svh"

module phe_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic [phe_pkg::OPC_W-1:0] req_opcode,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [phe_pkg::DATA_W-1:0] rsp_value,
    input logic                      rsp_overflow
);
    import phe_pkg::*;

    // a stalled result beat holds
    `PHE_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_overflow))

    // an evaluation keeps the request side busy
    `PHE_ASSERT_NEXT(a_eval_busy, clk, rst_n, req_valid && req_ready && (req_opcode == OP_EVAL || req_opcode == OP_DERIV), !req_ready)

    // loads and dropped codes leave the block free
    `PHE_ASSERT_NEXT(a_load_free, clk, rst_n, req_valid && req_ready && req_opcode != OP_EVAL && req_opcode != OP_DERIV, req_ready)

    // a new result only appears as the block leaves a busy phase
    `PHE_ASSERT_IMPL(a_rsp_after_busy, clk, rst_n, $rose(rsp_valid), req_ready && !$past(req_ready))

endmodule

bind polynomial_horner_evaluator_unit phe_checker u_phe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_opcode   (req.opcode),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_value    (rsp.value),
    .rsp_overflow (rsp.overflow)
);

### tb/sv/horner_result_checker.sv
`timescale 1ns / 100ps
// horner_result_checker: watches the degree writes and the req/rsp beats of the
// horner evaluator, predicts each result and compares it. depends on phe_pkg, phe_in_if, phe_out_if
module horner_result_checker #(
    parameter int MAX_DEGREE = 15
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [phe_pkg::DEG_W-1:0] cfg_wr_data,
    phe_in_if                         req,
    phe_out_if                        rsp,
    output int                        fail_count,
    output int                        pending
);
    import phe_pkg::*;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     overflow;
    } poly_result_t;

    logic signed [DATA_W-1:0] coef_mem [MAX_DEGREE+1];
    logic [DEG_W-1:0]         degree;
    poly_result_t             expected_results [$];

    function automatic bit outside_q(input longint v);
        return (v > Q_HI) || (v < Q_LO);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
        if (v > Q_HI)
            return 32'sh7fff_ffff;
        else if (v < Q_LO)
            return 32'sh8000_0000;
        else
            return 32'(v);
    endfunction

    function automatic poly_result_t horner_value(input opcode_t op,
                                                  input logic signed [DATA_W-1:0] x);
        logic signed [DATA_W-1:0] terms [MAX_DEGREE+1];
        logic signed [DATA_W-1:0] acc;
        longint                   t;
        int                       steps;
        logic                     ovf;
        poly_result_t             r;
        ovf = 1'b0;
        steps = int'(degree);
        for (int i = 0; i <= MAX_DEGREE; i++)
            terms[i] = coef_mem[i];
        if (op == OP_DERIV)
        begin
            // coefficient i stands for power degree - i
            for (int i = 0; i < int'(degree); i++)
            begin
                t = longint'(int'(degree) - i) * longint'(coef_mem[i]);
                ovf |= outside_q(t);
                terms[i] = clamp_q(t);
            end
            steps = int'(degree) - 1;
        end
        acc = terms[0];
        for (int i = 0; i < steps; i++)
        begin
            // arithmetic shift floors the q16.16 product
            t = (longint'(acc) * longint'(x)) >>> FRAC_W;
            ovf |= outside_q(t);
            acc = clamp_q(t);
            t = longint'(acc) + longint'(terms[i+1]);
            ovf |= outside_q(t);
            acc = clamp_q(t);
        end
        if (op == OP_DERIV && degree == '0)
        begin
            r.value = '0;
            r.overflow = 1'b0;
        end
        else
        begin
            r.value = acc;
            r.overflow = ovf;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        poly_result_t want;
        if (!rst_n)
        begin
            degree = '0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
                degree = (cfg_wr_data > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : cfg_wr_data;
            // responses first: a beat on this edge belongs to an earlier request
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: unexpected rsp beat value %h overflow %b",
                                 $time, rsp.value, rsp.overflow);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.value !== want.value || rsp.overflow !== want.overflow)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("%0t: rsp mismatch expected %h/%b got %h/%b",
                                     $time, want.value, want.overflow,
                                     rsp.value, rsp.overflow);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                case (req.opcode)
                    OP_LOAD:
                    begin
                        if (req.coeff_index <= MAX_DEGREE)
                            coef_mem[req.coeff_index] = req.coeff_value;
                    end
                    OP_EVAL, OP_DERIV:
                        expected_results.push_back(horner_value(opcode_t'(req.opcode),
                                                                req.point));
                    default: ;
                endcase
            end
            pending = expected_results.size();
        end
    end

endmodule

### tb/sv/polynomial_horner_evaluator_unit_tb.sv
`timescale 1ns / 100ps
// top of the horner evaluator testbench: clock, reset, degree writes, request and
// response traffic and the verdict. depends on phe_pkg, the channel interfaces and horner_result_checker
module polynomial_horner_evaluator_unit_tb;
    import phe_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int MAX_DEG       = 15;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 30;
    localparam int LONG_HOLD     = 400;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 245;
    localparam int COEF_SPAN     = 32'h0004_0000;
    localparam int POINT_SPAN    = 32'h0001_4000;

    localparam logic [OPC_W-1:0]         OP_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] Q_MAX     = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN     = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh0001_0000;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [DEG_W-1:0] cfg_wr_data;
    int               fail_count;
    int               pending;
    int               send_idle_pct;
    int               rsp_stall_pct;
    int               hold_requests;

    phe_in_if  req_if ();
    phe_out_if rsp_if ();

    polynomial_horner_evaluator_unit #(
        .MAX_DEGREE (MAX_DEG)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if),
        .rsp         (rsp_if)
    );

    horner_result_checker #(
        .MAX_DEGREE (MAX_DEG)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if),
        .rsp         (rsp_if),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Regression FAIL");
        $finish;
    end

    // rsp side: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        int stall_left;
        int holds_served;
        stall_left = 0;
        holds_served = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_q(input int span);
        logic signed [DATA_W-1:0] q;
        case ($urandom_range(19))
            0, 1, 2: q = $urandom;
            3:       q = Q_MAX;
            4:       q = Q_MIN;
            5:       q = Q_ONE;
            6:       q = -Q_ONE;
            7:       q = $urandom_range(1) ? 32'sd1 : -32'sd1;
            8:       q = '0;
            default: q = int'($urandom_range(2 * span)) - span;
        endcase
        return q;
    endfunction

    // returns on the accepting edge, or later if the sender idles after the beat
    task automatic send_item(input logic [OPC_W-1:0]         op,
                             input logic [IDX_W-1:0]         idx,
                             input logic signed [DATA_W-1:0] cv,
                             input logic signed [DATA_W-1:0] x);
        req_if.valid       <= 1'b1;
        req_if.opcode      <= op;
        req_if.coeff_index <= idx;
        req_if.coeff_value <= cv;
        req_if.point       <= x;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        // a trailing load may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_degree(input int deg);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= DEG_W'(deg);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic signed [DATA_W-1:0] coef;
        int                       deg;
        int                       pick;
        int                       sent;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        req_if.valid       = 1'b0;
        req_if.opcode      = OP_LOAD;
        req_if.coeff_index = '0;
        req_if.coeff_value = '0;
        req_if.point       = '0;
        send_idle_pct      = 0;
        rsp_stall_pct      = 0;
        hold_requests      = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every slot so that no evaluation reads an unwritten coefficient
        for (int i = 0; i <= MAX_DEG; i++)
        begin
            case (i)
                0:       coef = Q_MAX;
                1:       coef = Q_MIN;
                2:       coef = Q_ONE;
                3:       coef = -Q_ONE;
                default: coef = rand_q(COEF_SPAN);
            endcase
            send_item(OP_LOAD, IDX_W'(i), coef, $urandom);
        end
        // degree 0 after reset: constant, derivative of a constant, dropped opcode
        send_item(OP_EVAL, '0, '0, Q_MIN);
        send_item(OP_DERIV, '0, '0, Q_MAX);
        send_item(OP_UNUSED, '0, '0, Q_ONE);
        send_item(OP_EVAL, '1, '1, Q_ONE);
        drain_results();
        write_degree(MAX_DEG);
        send_item(OP_EVAL, '0, '0, Q_MAX);
        send_item(OP_EVAL, '0, '0, Q_MIN);
        send_item(OP_DERIV, '0, '0, Q_ONE);
        send_item(OP_EVAL, '0, '0, '0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            case (p)
                0:       deg = MAX_DEG;
                1:       deg = 0;
                2:       deg = 3;
                3:       deg = MAX_DEG;
                4:       deg = 1;
                5:       deg = 9;
                default: deg = $urandom_range(MAX_DEG);
            endcase
            write_degree(deg);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    rsp_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    rsp_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct = 21;
                    rsp_stall_pct = 21;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // rsp holds off while requests keep coming, so the unit backs up
                if (p == 0 && sent == 40)
                    hold_requests <= hold_requests + 1;
                if (p == 3 && sent == PHASE_ITEMS / 2)
                    drain_results();
                pick = $urandom_range(99);
                if (pick < 3)
                    send_item(OP_UNUSED, IDX_W'($urandom), $urandom, $urandom);
                else
                begin
                    if (pick < 40)
                        send_item(OP_LOAD, IDX_W'($urandom_range(MAX_DEG)),
                                  rand_q(COEF_SPAN), $urandom);
                    else if (pick < 70)
                        send_item(OP_EVAL, IDX_W'($urandom), $urandom, rand_q(POINT_SPAN));
                    else
                        send_item(OP_DERIV, IDX_W'($urandom), $urandom, rand_q(POINT_SPAN));
                    sent++;
                end
            end
        end
        drain_results();

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### polynomial_horner_evaluator_unit.f
+incdir+hw/rtl
hw/rtl/phe_pkg.sv
hw/rtl/phe_in_if.sv
hw/rtl/phe_out_if.sv
hw/rtl/phe_coeff_ram.sv
hw/rtl/phe_mac.sv
hw/rtl/polynomial_horner_evaluator_unit.sv
hw/rtl/phe_checker.sv
tb/sv/horner_result_checker.sv
tb/sv/polynomial_horner_evaluator_unit_tb.sv
